// File: rtl/core/akf_pkg.sv
// Package for the angle Kalman filter: types, register indexes, defaults and a saturating helper.
`default_nettype none
package akf_pkg;
    localparam int unsigned NoiseW = 31;
    localparam logic [NoiseW-1:0] AngleNoiseDefault = 31'd16777;
    localparam logic [NoiseW-1:0] BiasNoiseDefault  = 31'd50331;
    localparam logic [NoiseW-1:0] MeasNoiseDefault  = 31'd503316;

    localparam logic [1:0] RegAngleNoise = 2'd0;
    localparam logic [1:0] RegBiasNoise  = 2'd1;
    localparam logic [1:0] RegMeasNoise  = 2'd2;

    typedef enum logic [4:0] {
        t_idle,
        t_rate,
        t_ang_mul,
        t_t_mul,
        t_p00_mul,
        t_p11_mul,
        t_div_init,
        t_div_run,
        t_div_done,
        t_y_calc,
        t_ka_mul,
        t_kb_mul,
        t_c00_mul,
        t_c01_mul,
        t_c10_mul,
        t_c11_mul,
        t_out
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) r = 32'sh7fffffff;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/angle_kalman_filter.sv
// Top level of the two-state angle Kalman filter with a shared multiplier and divider.
`default_nettype none
// Channel  | Direction | Handshake            | Word
// input    | in        | i_valid / o_ready    | measured_angle, measured_rate, time_step
// result   | out       | o_valid / i_ready    | filtered_angle
// config   | in        | i_cfg_valid/o_cfg_ready | register index, write data
//
// One word runs through fourteen sequencer steps around one shared 34x34 signed
// multiplier, one restoring divider loop that computes both gains side by side
// (one quotient bit per cycle for each gain), and an output state that hands off
// the result and returns to idle. o_valid is registered and rises once the last
// correction step has run. Reset is synchronous and active low; it loads the
// default noise values and clears the angle, bias and covariance state. The input
// is not ready from acceptance until the result has been taken; the result waits
// in its output register while i_ready is low, which holds off the next word.
module angle_kalman_filter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_measured_angle,
    input  wire logic signed [31:0] i_measured_rate,
    input  wire logic        [15:0] i_time_step,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_filtered_angle,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic        [1:0]  i_cfg_index,
    input  wire logic        [31:0] i_cfg_data
);
    localparam int unsigned QW = 57; // dividend bits: |P|*2^24 < 2^57

    akf_pkg::t_state r_state, n_state;

    logic [30:0] r_qa, r_qb, r_r;
    logic signed [31:0] r_z, r_w, r_ang, r_bias, r_rate, r_y;
    logic [15:0] r_dt;
    logic signed [31:0] r_p00, r_p01, r_p10, r_p11, r_t, r_o00, r_o01;
    logic signed [31:0] r_k0, r_k1;
    logic signed [31:0] r_out;
    logic r_ovalid;

    // Divider state: magnitude of S, two partial remainders, two quotients.
    logic [32:0] r_dv;
    logic [57:0] r_q0, r_q1;
    logic [33:0] r_rm0, r_rm1;
    logic [56:0] r_nm0, r_nm1;
    logic r_sg0, r_sg1, r_szero;
    logic [5:0] r_cnt;

    // Shared multiplier, operands picked by the sequencer.
    logic signed [33:0] m_a, m_b;
    logic signed [67:0] m_p;
    logic [5:0] m_sh;
    logic signed [65:0] m_rnd;

    always_comb begin
        m_a = '0;
        m_b = '0;
        m_sh = 6'd16;
        unique case (r_state)
            akf_pkg::t_ang_mul: begin m_a = {18'd0, r_dt}; m_b = 34'(r_rate); end
            akf_pkg::t_t_mul:   begin m_a = {18'd0, r_dt}; m_b = 34'(r_p11); end
            akf_pkg::t_p00_mul: begin
                m_a = {18'd0, r_dt};
                m_b = 34'(r_t) - 34'(r_p01) - 34'(r_p10) + {3'd0, r_qa};
            end
            akf_pkg::t_p11_mul: begin m_a = {18'd0, r_dt}; m_b = {3'd0, r_qb}; end
            akf_pkg::t_ka_mul:  begin m_a = 34'(r_k0); m_b = 34'(r_y); m_sh = 6'd24; end
            akf_pkg::t_kb_mul:  begin m_a = 34'(r_k1); m_b = 34'(r_y); m_sh = 6'd24; end
            akf_pkg::t_c00_mul: begin m_a = 34'(r_k0); m_b = 34'(r_o00); m_sh = 6'd24; end
            akf_pkg::t_c01_mul: begin m_a = 34'(r_k0); m_b = 34'(r_o01); m_sh = 6'd24; end
            akf_pkg::t_c10_mul: begin m_a = 34'(r_k1); m_b = 34'(r_o00); m_sh = 6'd24; end
            akf_pkg::t_c11_mul: begin m_a = 34'(r_k1); m_b = 34'(r_o01); m_sh = 6'd24; end
            default: ;
        endcase
        m_p = m_a * m_b;
        // Round to nearest with ties up: add half, then arithmetic shift (floor).
        m_rnd = 66'((m_p + (68'sd1 <<< (m_sh - 6'd1))) >>> m_sh);
    end

    // Divider step helpers.
    logic [33:0] d_t0, d_t1;
    logic signed [32:0] s_full;
    logic signed [57:0] q0s, q1s;
    always_comb begin
        d_t0 = {r_rm0[32:0], r_nm0[56]};
        d_t1 = {r_rm1[32:0], r_nm1[56]};
        s_full = 33'(r_p00) + {2'd0, r_r};
        q0s = r_sg0 ? -$signed(r_q0) : $signed(r_q0);
        q1s = r_sg1 ? -$signed(r_q1) : $signed(r_q1);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            akf_pkg::t_idle:     if (i_valid) n_state = akf_pkg::t_rate;
            akf_pkg::t_rate:     n_state = akf_pkg::t_ang_mul;
            akf_pkg::t_ang_mul:  n_state = akf_pkg::t_t_mul;
            akf_pkg::t_t_mul:    n_state = akf_pkg::t_p00_mul;
            akf_pkg::t_p00_mul:  n_state = akf_pkg::t_p11_mul;
            akf_pkg::t_p11_mul:  n_state = akf_pkg::t_div_init;
            akf_pkg::t_div_init: n_state = akf_pkg::t_div_run;
            akf_pkg::t_div_run:  if (r_cnt == 6'(QW - 1)) n_state = akf_pkg::t_div_done;
            akf_pkg::t_div_done: n_state = akf_pkg::t_y_calc;
            akf_pkg::t_y_calc:   n_state = akf_pkg::t_ka_mul;
            akf_pkg::t_ka_mul:   n_state = akf_pkg::t_kb_mul;
            akf_pkg::t_kb_mul:   n_state = akf_pkg::t_c00_mul;
            akf_pkg::t_c00_mul:  n_state = akf_pkg::t_c01_mul;
            akf_pkg::t_c01_mul:  n_state = akf_pkg::t_c10_mul;
            akf_pkg::t_c10_mul:  n_state = akf_pkg::t_c11_mul;
            akf_pkg::t_c11_mul:  n_state = akf_pkg::t_out;
            akf_pkg::t_out:      if (!r_ovalid) n_state = akf_pkg::t_idle;
            default:             n_state = akf_pkg::t_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= akf_pkg::t_idle;
        else r_state <= n_state;
    end

    assign o_ready = (r_state == akf_pkg::t_idle);
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_ovalid;
    assign o_filtered_angle = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= akf_pkg::AngleNoiseDefault;
            r_qb <= akf_pkg::BiasNoiseDefault;
            r_r  <= akf_pkg::MeasNoiseDefault;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                akf_pkg::RegAngleNoise: r_qa <= i_cfg_data[30:0];
                akf_pkg::RegBiasNoise:  r_qb <= i_cfg_data[30:0];
                akf_pkg::RegMeasNoise:  r_r  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (r_state == akf_pkg::t_c11_mul) r_ovalid <= 1'b1;
        else if (i_ready) r_ovalid <= 1'b0;
    end

    // Filter state and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang <= '0; r_bias <= '0; r_rate <= '0;
            r_p00 <= '0; r_p01 <= '0; r_p10 <= '0; r_p11 <= '0;
        end else begin
            case (r_state)
                akf_pkg::t_idle: if (i_valid) begin
                    r_z <= i_measured_angle; r_w <= i_measured_rate; r_dt <= i_time_step;
                end
                akf_pkg::t_rate: r_rate <= akf_pkg::sat32(66'(r_w) - 66'(r_bias));
                akf_pkg::t_ang_mul: r_ang <= akf_pkg::sat32(66'(r_ang) + m_rnd);
                akf_pkg::t_t_mul: r_t <= 32'(m_rnd);
                akf_pkg::t_p00_mul: begin
                    r_p00 <= akf_pkg::sat32(66'(r_p00) + m_rnd);
                    r_p01 <= akf_pkg::sat32(66'(r_p01) - 66'(r_t));
                    r_p10 <= akf_pkg::sat32(66'(r_p10) - 66'(r_t));
                end
                akf_pkg::t_p11_mul: r_p11 <= akf_pkg::sat32(66'(r_p11) + m_rnd);
                akf_pkg::t_div_init: begin
                    // Sign-magnitude setup for both gain divisions.
                    r_szero <= (s_full == '0);
                    r_dv <= s_full[32] ? 33'(-s_full) : 33'(s_full);
                    r_nm0 <= 57'((r_p00[31] ? -57'(signed'(r_p00)) : 57'(r_p00)) << 24);
                    r_nm1 <= 57'((r_p10[31] ? -57'(signed'(r_p10)) : 57'(r_p10)) << 24);
                    r_sg0 <= r_p00[31] ^ s_full[32];
                    r_sg1 <= r_p10[31] ^ s_full[32];
                    r_rm0 <= '0; r_rm1 <= '0; r_q0 <= '0; r_q1 <= '0; r_cnt <= '0;
                end
                akf_pkg::t_div_run: begin
                    r_cnt <= r_cnt + 6'd1;
                    r_nm0 <= r_nm0 << 1;
                    r_nm1 <= r_nm1 << 1;
                    if (d_t0 >= {1'b0, r_dv}) begin
                        r_rm0 <= d_t0 - {1'b0, r_dv}; r_q0 <= {r_q0[56:0], 1'b1};
                    end else begin
                        r_rm0 <= d_t0; r_q0 <= {r_q0[56:0], 1'b0};
                    end
                    if (d_t1 >= {1'b0, r_dv}) begin
                        r_rm1 <= d_t1 - {1'b0, r_dv}; r_q1 <= {r_q1[56:0], 1'b1};
                    end else begin
                        r_rm1 <= d_t1; r_q1 <= {r_q1[56:0], 1'b0};
                    end
                end
                akf_pkg::t_div_done: begin
                    r_k0 <= r_szero ? '0 : akf_pkg::sat32(66'(q0s));
                    r_k1 <= r_szero ? '0 : akf_pkg::sat32(66'(q1s));
                end
                akf_pkg::t_y_calc: begin
                    r_y <= akf_pkg::sat32(66'(r_z) - 66'(r_ang));
                    r_o00 <= r_p00; r_o01 <= r_p01;
                end
                akf_pkg::t_ka_mul: r_ang <= akf_pkg::sat32(66'(r_ang) + m_rnd);
                akf_pkg::t_kb_mul: r_bias <= akf_pkg::sat32(66'(r_bias) + m_rnd);
                akf_pkg::t_c00_mul: r_p00 <= akf_pkg::sat32(66'(r_p00) - m_rnd);
                akf_pkg::t_c01_mul: r_p01 <= akf_pkg::sat32(66'(r_p01) - m_rnd);
                akf_pkg::t_c10_mul: r_p10 <= akf_pkg::sat32(66'(r_p10) - m_rnd);
                akf_pkg::t_c11_mul: begin
                    r_p11 <= akf_pkg::sat32(66'(r_p11) - m_rnd);
                    r_out <= r_ang;
                end
                default: ;
            endcase
        end
    end

    // The input is only taken while the sequencer is idle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != akf_pkg::t_idle) |-> !o_ready) else $error("ready while busy");
    // A result appears only right after the last correction step.
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == akf_pkg::t_c11_mul) else $error("stray result");
    // The divider loop never overruns its bit count.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == akf_pkg::t_div_run) |-> (r_cnt < 6'(QW))) else $error("divider overrun");
endmodule
`default_nettype wire

// File: tb/sv/tb_angle_kalman_filter.sv
// Testbench for the angle Kalman filter: random and directed words checked against a predictor.
`default_nettype none
module tb_angle_kalman_filter;
    timeunit 1ns;
    timeprecision 1ps;

    // Index past the last register; a write to it must be ignored.
    localparam logic [1:0] RegUnused = 2'd3;
    // Cycles without any handshake on any channel before the run is declared hung.
    localparam int IdleLimit = 20000;
    // Drain time after the last result.
    localparam int SettleCycles = 120;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_measured_angle = '0;
    logic signed [31:0] i_measured_rate = '0;
    logic        [15:0] i_time_step = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_filtered_angle;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic        [1:0]  i_cfg_index = '0;
    logic        [31:0] i_cfg_data = '0;

    angle_kalman_filter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_measured_angle(i_measured_angle), .i_measured_rate(i_measured_rate),
        .i_time_step(i_time_step),
        .o_valid(o_valid), .i_ready(i_ready), .o_filtered_angle(o_filtered_angle),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor state: registers, estimates and the covariance P00, P01, P10, P11.
    longint noise_angle, noise_bias, noise_meas;
    longint est_angle, est_bias, est_rate;
    longint cov [4];

    logic signed [31:0] angle_queue [$];
    int errors = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Round to nearest with ties toward plus infinity; >>> on a signed value is a floor.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    task automatic filter_reset();
        noise_angle = longint'(akf_pkg::AngleNoiseDefault);
        noise_bias  = longint'(akf_pkg::BiasNoiseDefault);
        noise_meas  = longint'(akf_pkg::MeasNoiseDefault);
        est_angle = 0;
        est_bias = 0;
        est_rate = 0;
        foreach (cov[i]) cov[i] = 0;
    endtask

    // One predict, gain and correct pass; returns the new angle estimate.
    function automatic logic signed [31:0] filter_step(input logic signed [31:0] z_in,
                                                       input logic signed [31:0] w_in,
                                                       input logic [15:0] dt_in);
        longint z, w, dt, p00, p01, p10, p11, t, inner, s, k0, k1, y, p00o, p01o;
        z = z_in;
        w = w_in;
        dt = dt_in;
        p00 = cov[0];
        p01 = cov[1];
        p10 = cov[2];
        p11 = cov[3];
        est_rate = clamp32(w - est_bias);
        est_angle = clamp32(est_angle + round_shift(dt * est_rate, 16));
        t = round_shift(dt * p11, 16);
        inner = t - p01 - p10 + noise_angle;
        p00 = clamp32(p00 + round_shift(dt * inner, 16));
        p01 = clamp32(p01 - t);
        p10 = clamp32(p10 - t);
        p11 = clamp32(p11 + round_shift(noise_bias * dt, 16));
        // A zero innovation variance leaves both gains at zero.
        s = p00 + noise_meas;
        k0 = 0;
        k1 = 0;
        if (s != 0) begin
            k0 = clamp32((p00 <<< 24) / s);
            k1 = clamp32((p10 <<< 24) / s);
        end
        y = clamp32(z - est_angle);
        est_angle = clamp32(est_angle + round_shift(k0 * y, 24));
        est_bias = clamp32(est_bias + round_shift(k1 * y, 24));
        p00o = p00;
        p01o = p01;
        cov[0] = clamp32(p00 - round_shift(k0 * p00o, 24));
        cov[1] = clamp32(p01 - round_shift(k0 * p01o, 24));
        cov[2] = clamp32(p10 - round_shift(k1 * p00o, 24));
        cov[3] = clamp32(p11 - round_shift(k1 * p01o, 24));
        return est_angle[31:0];
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // A field value: full random half of the time, else an extreme or a small value.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom();
        if (r == 5) return 32'h7fffffff;
        if (r == 6) return 32'h80000000;
        return $urandom_range(0, 1 << 22) - (1 << 21);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    // Send one word; expects to start and end at a falling edge.
    task automatic send_word(input logic signed [31:0] angle, input logic signed [31:0] rate,
                             input logic [15:0] dt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_measured_angle <= angle;
        i_measured_rate <= rate;
        i_time_step <= dt;
        angle_queue.push_back(filter_step(angle, rate, dt));
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Wait until every expected result has come and the block has settled.
    task automatic drain();
        i_valid <= 1'b0;
        while (angle_queue.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            akf_pkg::RegAngleNoise: noise_angle = data[30:0];
            akf_pkg::RegBiasNoise:  noise_bias = data[30:0];
            akf_pkg::RegMeasNoise:  noise_meas = data[30:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) begin
            if ($urandom_range(0, 3) == 0)
                send_word(pick_value(), pick_value(), 16'($urandom()));
            else
                send_word($urandom_range(0, 1 << 24) - (1 << 23),
                          $urandom_range(0, 1 << 20) - (1 << 19),
                          16'($urandom_range(0, 1500)));
        end
    endtask

    // Field extremes, zero time step and full-scale time step at default noise.
    task automatic test_extremes();
        send_word(32'sd0, 32'sd0, 16'd0);
        send_word(32'sd65536, 32'sd0, 16'd655);
        send_word(32'sh7fffffff, 32'sh7fffffff, 16'hffff);
        send_word(32'sh80000000, 32'sh80000000, 16'hffff);
        send_word(32'sh7fffffff, 32'sh80000000, 16'd0);
        send_word(32'sh80000000, 32'sh7fffffff, 16'd1);
        send_word(-32'sd65536, 32'sd1000, 16'd0);
        repeat (5) send_word(pick_value(), pick_value(), 16'($urandom()));
        drain();
    endtask

    // Register extremes: zero measurement noise can make the innovation variance zero,
    // bit 31 of the data is dropped, and the spare index is ignored.
    task automatic test_registers();
        write_reg(akf_pkg::RegAngleNoise, 32'd0);
        write_reg(akf_pkg::RegBiasNoise, 32'd0);
        write_reg(akf_pkg::RegMeasNoise, 32'd0);
        write_reg(RegUnused, 32'hffffffff);
        send_word(32'sd100000, 32'sd5000, 16'd0);
        send_word(32'sd100000, 32'sd5000, 16'd655);
        drain();
        write_reg(akf_pkg::RegAngleNoise, 32'hffffffff);
        write_reg(akf_pkg::RegBiasNoise, 32'hffffffff);
        write_reg(akf_pkg::RegMeasNoise, 32'h80000001);
        repeat (4) send_word(pick_value(), pick_value(), 16'hffff);
        drain();
        write_reg(akf_pkg::RegMeasNoise, 32'h7fffffff);
        repeat (4) send_word(pick_value(), pick_value(), 16'($urandom()));
        drain();
    endtask

    // Random words over several register settings, with one full pause mid-phase.
    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++) begin
            no_idle = (ph % 3 == 2);
            if (ph == 0) begin
                write_reg(akf_pkg::RegAngleNoise, 32'(akf_pkg::AngleNoiseDefault));
                write_reg(akf_pkg::RegBiasNoise, 32'(akf_pkg::BiasNoiseDefault));
                write_reg(akf_pkg::RegMeasNoise, 32'(akf_pkg::MeasNoiseDefault));
            end else begin
                write_reg(2'($urandom_range(0, 3)), $urandom());
                write_reg(akf_pkg::RegAngleNoise, $urandom_range(0, 1 << 20));
                write_reg(akf_pkg::RegMeasNoise, $urandom_range(1, 1 << 24));
                if (ph == 4) write_reg(akf_pkg::RegBiasNoise, $urandom());
                else write_reg(akf_pkg::RegBiasNoise, $urandom_range(0, 1 << 20));
            end
            send_random(118);
            if (ph == 1) drain();
            send_random(118);
            drain();
        end
        no_idle = 1'b0;
    endtask

    always @(negedge i_clk) begin : ready_gen
        int hold;
        if (hold > 0) begin
            hold--;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_ready <= 1'b0;
            hold = pick_gap();
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare every accepted result with the oldest expected angle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (angle_queue.size() == 0)
                report_mismatch("unexpected result", 32'h0, o_filtered_angle);
            else if (o_filtered_angle !== angle_queue[0])
                report_mismatch("filtered_angle", angle_queue.pop_front(), o_filtered_angle);
            else
                void'(angle_queue.pop_front());
        end
    end

    // A hung block shows up as a long run of cycles with nothing accepted.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        filter_reset();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_registers();
        test_random_phases();
        drain();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: angle_kalman_filter.f
rtl/core/akf_pkg.sv
rtl/core/angle_kalman_filter.sv
tb/sv/tb_angle_kalman_filter.sv
